// ===== rtl/core/pba_pkg.sv =====
`timescale 1ns / 1ps
package pba_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned NUM_SPACES = 3;
  localparam int unsigned SPACE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'd4096;
  localparam logic [ADDR_W-1:0] ONE_BYTE   = 64'd1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_ALIGN = 1'b1;

  localparam logic [SPACE_W-1:0] SPACE_IO    = 2'd0;
  localparam logic [SPACE_W-1:0] SPACE_MEM32 = 2'd1;
  localparam logic [SPACE_W-1:0] SPACE_MEM64 = 2'd2;
  localparam logic [SPACE_W-1:0] SPACE_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IO_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IO_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEM32_BASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEM32_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEM64_BASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEM64_SIZE = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0] step;
    logic [ADDR_W-1:0] step_m1;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] top;
    logic [ADDR_W-1:0] lim;
    logic              lim_inf;
  } win_t;

  typedef win_t [NUM_SPACES-1:0] win_arr_t;

  typedef struct packed {
    logic               valid;
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  top;
  } upd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic              ok;
  } rsp_t;

endpackage

// ===== rtl/core/pba_if.sv =====
`timescale 1ns / 1ps
interface pba_req_if;
  import pba_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SPACE_W-1:0] space;
  logic [ADDR_W-1:0]  amount;

  modport source (output valid, output mode, output space, output amount, input ready);
  modport sink   (input valid, input mode, input space, input amount, output ready);
endinterface

interface pba_rsp_if;
  import pba_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_addr;
  logic              ok;

  modport source (output valid, output block_addr, output ok, input ready);
  modport sink   (input valid, input block_addr, input ok, output ready);
endinterface

// ===== rtl/core/pba_window_regs.sv =====
`timescale 1ns / 1ps
module pba_window_regs
  import pba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  input  upd_t                 upd_i,
  output win_arr_t             wins_o
);

  logic [NUM_SPACES-1:0][ADDR_W-1:0] base_q, base_d;
  logic [NUM_SPACES-1:0][ADDR_W-1:0] size_q, size_d;
  logic [NUM_SPACES-1:0][ADDR_W-1:0] top_q, top_d;
  logic [NUM_SPACES-1:0][ADDR_W-1:0] lim_q, lim_d;
  logic [NUM_SPACES-1:0]             inf_q, inf_d;
  logic [ADDR_W:0]                   lim_sum;
  logic [SPACE_W-1:0]                cfg_sp;
  logic [1:0]                        cfg_sel;

  assign cfg_sp = cfg_idx_i[CFG_IDX_W-1:1];

  always_comb begin
    base_d  = base_q;
    size_d  = size_q;
    top_d   = top_q;
    lim_d   = lim_q;
    inf_d   = inf_q;
    lim_sum = '0;
    cfg_sel = '0;
    case (cfg_sp)
      SPACE_IO:    cfg_sel = 2'd0;
      SPACE_MEM32: cfg_sel = 2'd1;
      SPACE_MEM64: cfg_sel = 2'd2;
      default:     cfg_sel = 2'd0;
    endcase
    if (cfg_we_i && (cfg_sp != SPACE_NONE)) begin
      if (!cfg_idx_i[0]) begin
        base_d[cfg_sel] = cfg_wdata_i;
        top_d[cfg_sel]  = cfg_wdata_i;
        lim_sum         = {1'b0, cfg_wdata_i} + {1'b0, size_q[cfg_sel]};
      end else begin
        size_d[cfg_sel] = cfg_wdata_i;
        lim_sum         = {1'b0, base_q[cfg_sel]} + {1'b0, cfg_wdata_i};
      end
      lim_d[cfg_sel] = lim_sum[ADDR_W-1:0];
      inf_d[cfg_sel] = lim_sum[ADDR_W];
    end else if (upd_i.valid) begin
      case (upd_i.space)
        SPACE_IO:    top_d[0] = upd_i.top;
        SPACE_MEM32: top_d[1] = upd_i.top;
        SPACE_MEM64: top_d[2] = upd_i.top;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= '0;
      top_q  <= '0;
      lim_q  <= '0;
      inf_q  <= '0;
    end else begin
      base_q <= base_d;
      size_q <= size_d;
      top_q  <= top_d;
      lim_q  <= lim_d;
      inf_q  <= inf_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SPACES; i++) begin
      wins_o[i].top     = top_q[i];
      wins_o[i].lim     = lim_q[i];
      wins_o[i].lim_inf = inf_q[i];
    end
  end

endmodule

// ===== rtl/core/pba_calc.sv =====
`timescale 1ns / 1ps
module pba_calc
  import pba_pkg::*;
(
  input  req_t     req_i,
  input  win_arr_t wins_i,
  output rsp_t     rsp_o,
  output logic [ADDR_W-1:0] new_top_o
);

  win_t              win;
  logic              sp_ok;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] aligned;
  logic [ADDR_W:0]   end_sum;
  logic [ADDR_W-1:0] chk;
  logic              in_lim;
  logic              is_alloc;

  always_comb begin
    win   = wins_i[0];
    sp_ok = 1'b1;
    case (req_i.space)
      SPACE_IO:    win = wins_i[0];
      SPACE_MEM32: win = wins_i[1];
      SPACE_MEM64: win = wins_i[2];
      default:     sp_ok = 1'b0;
    endcase

    is_alloc = (req_i.mode == MODE_ALLOC);
    sum      = {1'b0, win.top} + {1'b0, req_i.step_m1};
    aligned  = sum[ADDR_W-1:0] & ~req_i.step_m1;
    end_sum  = {1'b0, aligned} + {1'b0, req_i.step};
    chk      = is_alloc ? end_sum[ADDR_W-1:0] : aligned;
    in_lim   = win.lim_inf || (chk <= win.lim);

    rsp_o.ok = sp_ok && !sum[ADDR_W] && (!is_alloc || !end_sum[ADDR_W]) && in_lim;
    rsp_o.block_addr = (rsp_o.ok && is_alloc) ? aligned : '0;
    new_top_o = chk;
  end

endmodule

// ===== rtl/core/pci_window_bump_allocator_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// cfg       in   cfg_we_i             cfg_idx_i, cfg_wdata_i
// req_i     in   valid / ready        mode, space, amount
// rsp_o     out  valid / ready        block_addr, ok
//
// one request per cycle sustained while results are taken; a request passes req_q and then rsp_q
// the rate is set by the loop from the window tops through the align/limit logic
// reset clears windows, limits and tops to zero and empties both stages
// a stalled result holds the request stage; the request stage holds the input
module pci_window_bump_allocator_top
  import pba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  pba_req_if.sink              req_i,
  pba_rsp_if.source            rsp_o
);

  logic     req_vld_q;
  req_t     req_q, req_d;
  logic     rsp_vld_q;
  rsp_t     rsp_q, rsp_c;
  logic     advance;
  logic     in_fire;
  win_arr_t wins;
  upd_t     upd;
  logic [ADDR_W-1:0] new_top;

  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;
  assign in_fire     = req_i.valid && req_i.ready;

  // step prep
  always_comb begin
    req_d.mode  = req_i.mode;
    req_d.space = req_i.space;
    req_d.step  = req_i.amount;
    if (req_i.mode == MODE_ALLOC) begin
      if (req_i.amount < PAGE_BYTES) req_d.step = PAGE_BYTES;
    end else if (req_i.amount == '0) begin
      req_d.step = ONE_BYTE;
    end
    req_d.step_m1 = req_d.step - ONE_BYTE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  pba_window_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (upd),
    .wins_o      (wins)
  );

  pba_calc u_calc (
    .req_i     (req_q),
    .wins_i    (wins),
    .rsp_o     (rsp_c),
    .new_top_o (new_top)
  );

  assign upd.valid = advance && rsp_c.ok;
  assign upd.space = req_q.space;
  assign upd.top   = new_top;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (!rsp_vld_q || rsp_o.ready) begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_c;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.block_addr = rsp_q.block_addr;
  assign rsp_o.ok         = rsp_q.ok;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.block_addr == '0)
    else $error("failed request carries an address");

  a_upd_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd.valid |-> advance && req_q.space != SPACE_NONE)
    else $error("top moved without a request leaving the stage");

  a_stall_tops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp_o.ready && !cfg_we_i |=> $stable(wins))
    else $error("window top moved during output stall");

  a_hold_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_q && !advance |=> req_vld_q && $stable(req_q))
    else $error("stalled request lost");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pba_pkg::*;

  localparam int unsigned MAX_IDLE = 17;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned RANDOM_SETUPS = 8;
  localparam int unsigned REQS_PER_SETUP = 168;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] BASE_REG [NUM_SPACES] =
    '{REG_IO_BASE, REG_MEM32_BASE, REG_MEM64_BASE};
  localparam logic [CFG_IDX_W-1:0] SIZE_REG [NUM_SPACES] =
    '{REG_IO_SIZE, REG_MEM32_SIZE, REG_MEM64_SIZE};
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic               mode;
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  amount;
  } alloc_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_wdata_i;

  pba_req_if req_bus ();
  pba_rsp_if rsp_bus ();

  pci_window_bump_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // window model
  logic [ADDR_W-1:0] win_base [NUM_SPACES];
  logic [ADDR_W-1:0] win_size [NUM_SPACES];
  logic [ADDR_W-1:0] win_top  [NUM_SPACES];

  alloc_req_t req_backlog [$];
  rsp_t       grant_queue [$];

  int unsigned n_queued   = 0;
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_granted  = 0;
  int unsigned n_writes   = 0;
  int unsigned n_setups   = 0;
  int unsigned n_errors   = 0;
  int unsigned req_gap    = 0;
  int unsigned rsp_hold   = 0;
  bit          src_busy   = 1'b1;
  bit          snk_busy   = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(bit busy);
    return busy ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("ERROR %0t: %s", $time, msg);
  endfunction

  // rounds the window top up and, for an alloc, reserves the block; a grant updates the model top
  function automatic rsp_t predict_grant(logic mode, logic [SPACE_W-1:0] sp,
                                         logic [ADDR_W-1:0] amount);
    rsp_t              g;
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] stp;
    logic [ADDR_W-1:0] aligned;
    logic [ADDR_W:0]   sum;
    logic [ADDR_W:0]   fin;
    logic [ADDR_W:0]   lim;
    g = '0;
    if (sp == SPACE_NONE) return g;
    cur = win_top[sp];
    stp = amount;
    if (mode == MODE_ALLOC) begin
      if (stp < PAGE_BYTES) stp = PAGE_BYTES;
    end else if (stp == '0) begin
      stp = ONE_BYTE;
    end
    sum = {1'b0, cur} + {1'b0, stp - ONE_BYTE};
    if (sum[ADDR_W]) return g;
    aligned = sum[ADDR_W-1:0] & ~(stp - ONE_BYTE);
    lim = {1'b0, win_base[sp]} + {1'b0, win_size[sp]};
    if (mode == MODE_ALLOC) begin
      fin = {1'b0, aligned} + {1'b0, stp};
      if (fin[ADDR_W] || fin > lim) return g;
      win_top[sp] = fin[ADDR_W-1:0];
      g.block_addr = aligned;
      g.ok = 1'b1;
    end else begin
      if ({1'b0, aligned} > lim) return g;
      win_top[sp] = aligned;
      g.ok = 1'b1;
    end
    return g;
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive_req
    alloc_req_t nxt;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        grant_queue.push_back(predict_grant(req_bus.mode, req_bus.space, req_bus.amount));
        n_requests++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_bus.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_bus.valid  <= 1'b1;
          req_bus.mode   <= nxt.mode;
          req_bus.space  <= nxt.space;
          req_bus.amount <= nxt.amount;
          if ($urandom_range(0, 39) == 0) src_busy = !src_busy;
          req_gap = draw_wait(src_busy);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : watch_rsp
    rsp_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_results++;
        if (rsp_bus.ok) n_granted++;
        if (grant_queue.size() == 0) begin
          flag_error($sformatf("unexpected result block_addr=%h ok=%b",
                               rsp_bus.block_addr, rsp_bus.ok));
        end else begin
          want = grant_queue.pop_front();
          if (rsp_bus.block_addr !== want.block_addr || rsp_bus.ok !== want.ok)
            flag_error($sformatf("result %0d: block_addr exp %h got %h, ok exp %b got %b",
                                 n_results, want.block_addr, rsp_bus.block_addr,
                                 want.ok, rsp_bus.ok));
        end
        if ($urandom_range(0, 39) == 0) snk_busy = !snk_busy;
        rsp_hold = draw_wait(snk_busy);
      end else if (rsp_hold > 0) begin
        rsp_hold--;
      end
      rsp_bus.ready <= (rsp_hold == 0);
    end
  end

  task automatic queue_req(input logic mode, input logic [SPACE_W-1:0] sp,
                           input logic [ADDR_W-1:0] amount);
    alloc_req_t it;
    it.mode   = mode;
    it.space  = sp;
    it.amount = amount;
    req_backlog.push_back(it);
    n_queued++;
  endtask

  // wait until every queued request has come back as a result
  task automatic drain;
    while (n_results < n_queued)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    n_writes++;
    case (idx)
      REG_IO_BASE:    begin win_base[0] = val; win_top[0] = val; end
      REG_MEM32_BASE: begin win_base[1] = val; win_top[1] = val; end
      REG_MEM64_BASE: begin win_base[2] = val; win_top[2] = val; end
      REG_IO_SIZE:    win_size[0] = val;
      REG_MEM32_SIZE: win_size[1] = val;
      REG_MEM64_SIZE: win_size[2] = val;
      default: ;
    endcase
  endtask

  task automatic end_writes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_setups++;
  endtask

  task automatic program_random_windows;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    for (int w = 0; w < NUM_SPACES; w++) begin
      case ($urandom_range(0, 9))
        0: begin b = '0; s = '0; end
        1: begin b = {$urandom, $urandom}; s = {$urandom, $urandom}; end
        2: begin b = 64'hFFFF_FFFF_FFF0_0000; s = 64'h1_0000_0000; end
        3: begin b = '0; s = ALL_ONES; end
        4: begin b = ALL_ONES; s = 64'd1 << $urandom_range(12, 20); end
        default: begin
          b = {$urandom, $urandom} >> $urandom_range(0, 40);
          s = 64'd1 << $urandom_range(14, 26);
        end
      endcase
      // size-only rewrite keeps the old top, which may now lie past the end
      if ($urandom_range(0, 2) != 0) write_reg(BASE_REG[w], b);
      write_reg(SIZE_REG[w], s);
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_LO, {$urandom, $urandom});
    end_writes();
  endtask

  function automatic alloc_req_t random_req;
    alloc_req_t  it;
    int unsigned r;
    it.space = ($urandom_range(0, 99) < 8) ? SPACE_NONE
                                           : SPACE_W'($urandom_range(SPACE_IO, SPACE_MEM64));
    it.mode  = ($urandom_range(0, 3) == 0) ? MODE_ALIGN : MODE_ALLOC;
    r = $urandom_range(0, 99);
    if (r < 5)       it.amount = '0;
    else if (r < 11) it.amount = {$urandom, $urandom};
    else if (r < 17) it.amount = 64'd1 << $urandom_range(0, 63);
    else if (r < 21) it.amount = (64'd1 << $urandom_range(12, 18)) + (64'd1 << $urandom_range(0, 11));
    else             it.amount = 64'd1 << $urandom_range(0, 17);
    return it;
  endfunction

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    req_bus.valid = 1'b0;
    req_bus.mode  = MODE_ALLOC;
    req_bus.space = SPACE_IO;
    req_bus.amount = '0;
    rsp_bus.ready = 1'b0;
    for (int w = 0; w < NUM_SPACES; w++) begin
      win_base[w] = '0;
      win_size[w] = '0;
      win_top[w]  = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty windows straight out of reset
    queue_req(MODE_ALLOC, SPACE_IO, '0);
    queue_req(MODE_ALIGN, SPACE_MEM32, '0);
    queue_req(MODE_ALIGN, SPACE_MEM64, ONE_BYTE);
    queue_req(MODE_ALIGN, SPACE_NONE, '0);
    drain();

    write_reg(REG_IO_BASE, 64'h1000);
    write_reg(REG_IO_SIZE, 64'h1_0000);
    write_reg(REG_MEM32_BASE, 64'h8000_0000);
    write_reg(REG_MEM32_SIZE, 64'h1000_0000);
    write_reg(REG_MEM64_BASE, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(REG_MEM64_SIZE, 64'h1_0000);
    end_writes();
    // fill the io window up to its end exactly
    queue_req(MODE_ALLOC, SPACE_IO, '0);
    queue_req(MODE_ALLOC, SPACE_IO, ONE_BYTE);
    queue_req(MODE_ALLOC, SPACE_IO, 64'h2000);
    queue_req(MODE_ALLOC, SPACE_IO, 64'h8000);
    queue_req(MODE_ALLOC, SPACE_IO, 64'h1000);
    queue_req(MODE_ALLOC, SPACE_IO, 64'h1000);
    queue_req(MODE_ALIGN, SPACE_IO, '0);
    queue_req(MODE_ALIGN, SPACE_IO, 64'h1_0000);
    queue_req(MODE_ALLOC, SPACE_MEM32, 64'h3000);
    queue_req(MODE_ALLOC, SPACE_NONE, 64'h1000);
    // top near the 64-bit end, limit wraps
    queue_req(MODE_ALLOC, SPACE_MEM64, 64'h1_0000);
    queue_req(MODE_ALLOC, SPACE_MEM64, 64'h8000);
    queue_req(MODE_ALIGN, SPACE_MEM64, 64'h8000_0000_0000_0000);
    queue_req(MODE_ALLOC, SPACE_MEM64, 64'h8000_0000_0000_0000);
    queue_req(MODE_ALLOC, SPACE_MEM32, ALL_ONES);
    drain();

    // shrink io below its top, all-ones base on mem32, spare indexes
    write_reg(REG_IO_SIZE, 64'h1000);
    write_reg(REG_MEM32_BASE, ALL_ONES);
    write_reg(REG_MEM32_SIZE, '0);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, ALL_ONES);
    end_writes();
    queue_req(MODE_ALIGN, SPACE_IO, '0);
    queue_req(MODE_ALLOC, SPACE_IO, 64'h1000);
    queue_req(MODE_ALIGN, SPACE_MEM32, '0);
    queue_req(MODE_ALIGN, SPACE_MEM32, ONE_BYTE);
    queue_req(MODE_ALLOC, SPACE_MEM32, '0);
    drain();

    for (int p = 0; p < RANDOM_SETUPS; p++) begin
      program_random_windows();
      for (int i = 0; i < REQS_PER_SETUP; i++) begin
        req_backlog.push_back(random_req());
        n_queued++;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("checked %0d requests, %0d granted and %0d refused", n_results, n_granted,
             n_results - n_granted);
    $display("over %0d window setups with %0d register writes, %0d mismatches", n_setups,
             n_writes, n_errors);
    if (n_errors == 0) begin
      $display("pci_window_bump_allocator_top regression: pass");
    end else begin
      $display("pci_window_bump_allocator_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("timeout with %0d results still expected", grant_queue.size());
    $display("pci_window_bump_allocator_top regression: fail");
    $finish;
  end

endmodule
